@@ rtl/lcgbr_pkg.sv @@
// Shared types and constants of the 48-bit bounded random generator.
package lcgbr_pkg;

  localparam int unsigned StateW = 48;
  localparam int unsigned HalfW  = 24;
  localparam int unsigned DrawW  = 31;
  localparam int unsigned ValueW = 32;
  localparam int unsigned BitsW  = 6;
  localparam int unsigned CntW   = $clog2(DrawW);

  localparam logic [StateW-1:0] LcgMult = 48'h0005_DEEC_E66D;
  localparam logic [StateW-1:0] LcgAdd  = 48'h0000_0000_000B;
  localparam logic [HalfW-1:0]  MultLo  = LcgMult[HalfW-1:0];
  localparam logic [HalfW-1:0]  MultHi  = LcgMult[StateW-1:HalfW];
  localparam logic [CntW-1:0]   DivLast = CntW'(DrawW - 1);

  typedef enum logic [1:0] {
    ActSeed    = 2'd0,
    ActRaw     = 2'd1,
    ActBounded = 2'd2,
    ActUnused  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MulLoLo,
    MulHiLo,
    MulLoHi
  } mul_sel_e;

  typedef enum logic [2:0] {
    ResZero,
    ResErr,
    ResRaw,
    ResPow,
    ResRem
  } res_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     seed_load;
    logic     mac_en;
    mul_sel_e mul_sel;
    logic     state_commit;
    logic     div_clear;
    logic     div_step;
    logic     res_load;
    res_sel_e res_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    bound_zero;
    logic    bound_pow2;
    logic    div_last;
    logic    reject;
    logic    out_free;
  } status_t;

endpackage

@@ rtl/lcgbr_ctrl.sv @@
// Sequencer of the generator: decodes the item and steps the datapath.
module lcgbr_ctrl import lcgbr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    Idle,
    Decode,
    Mul0,
    Mul1,
    Mul2,
    Raw,
    Pow,
    Div,
    Check,
    Done
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != Idle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MulLoLo;
    cmd_o.res_sel = ResZero;
    unique case (state_q)
      Idle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = Decode;
        end
      end
      Decode: begin
        unique case (status_i.action)
          ActSeed: begin
            cmd_o.seed_load = 1'b1;
            cmd_o.res_load  = 1'b1;
            state_d = Done;
          end
          ActRaw: state_d = Mul0;
          ActBounded: begin
            if (status_i.bound_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = ResErr;
              state_d = Done;
            end else begin
              state_d = Mul0;
            end
          end
          default: begin
            cmd_o.res_load = 1'b1;
            state_d = Done;
          end
        endcase
      end
      Mul0: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mul_sel = MulLoLo;
        state_d = Mul1;
      end
      Mul1: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mul_sel = MulHiLo;
        state_d = Mul2;
      end
      Mul2: begin
        cmd_o.mac_en       = 1'b1;
        cmd_o.mul_sel      = MulLoHi;
        cmd_o.state_commit = 1'b1;
        cmd_o.div_clear    = 1'b1;
        priority if (status_i.action == ActRaw) begin
          state_d = Raw;
        end else if (status_i.bound_pow2) begin
          state_d = Pow;
        end else begin
          state_d = Div;
        end
      end
      Raw: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = ResRaw;
        state_d = Done;
      end
      Pow: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = ResPow;
        state_d = Done;
      end
      Div: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = Check;
        end
      end
      Check: begin
        if (status_i.reject) begin
          state_d = Mul0;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = ResRem;
          state_d = Done;
        end
      end
      Done: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/lcgbr_dp.sv @@
// Datapath: generator state, shared multiply-accumulate, serial remainder, result.
module lcgbr_dp import lcgbr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        in_action_i,
  input  logic [StateW-1:0] in_seed_word_i,
  input  logic [BitsW-1:0]  in_draw_bits_i,
  input  logic [DrawW-1:0]  in_bound_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] out_value_o,
  output logic              out_bound_error_o
);

  // item registers
  action_e           action_q;
  logic [StateW-1:0] seed_q;
  logic [BitsW-1:0]  bits_q;
  logic [DrawW-1:0]  bound_q;

  logic [StateW-1:0] state_q, state_d;
  logic [StateW-1:0] acc_q, acc_d;
  logic [HalfW-1:0]  mul_a, mul_b;
  logic [StateW-1:0] prod;

  logic [DrawW-1:0]  rem_q, rem_d;
  logic [DrawW-1:0]  shift_q;
  logic [CntW-1:0]   cnt_q;
  logic [ValueW-1:0] trial;
  logic [ValueW:0]   trial_diff;
  logic [ValueW-1:0] sum;

  logic [ValueW-1:0] res_value_q, res_value_d;
  logic              res_err_q, res_err_d;
  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_err_q;

  logic [DrawW-1:0]    draw;
  logic [BitsW-1:0]    bits_c;
  logic [BitsW-1:0]    raw_sh;
  logic [ValueW-1:0]   raw_value;
  logic [2*DrawW-1:0]  pow_prod;
  logic [DrawW-1:0]    bound_m1;

  assign draw = state_q[StateW-1 -: DrawW];

  // status back to the sequencer
  assign bound_m1 = bound_q - DrawW'(1);
  always_comb begin
    status_o.action     = action_q;
    status_o.bound_zero = (bound_q == '0);
    status_o.bound_pow2 = ((bound_q & bound_m1) == '0);
    status_o.div_last   = (cnt_q == DivLast);
    status_o.reject     = sum[ValueW-1];
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_e'(in_action_i);
      seed_q   <= in_seed_word_i;
      bits_q   <= in_draw_bits_i;
      bound_q  <= in_bound_i;
    end
  end

  // state * multiplier mod 2^48 from three 24x24 partial products;
  // the high*high product lies wholly above bit 47 and is dropped
  always_comb begin
    unique case (cmd_i.mul_sel)
      MulLoLo: begin mul_a = state_q[HalfW-1:0];      mul_b = MultLo; end
      MulHiLo: begin mul_a = state_q[StateW-1:HalfW]; mul_b = MultLo; end
      MulLoHi: begin mul_a = state_q[HalfW-1:0];      mul_b = MultHi; end
      default: begin mul_a = state_q[HalfW-1:0];      mul_b = MultLo; end
    endcase
    prod = StateW'(mul_a) * StateW'(mul_b);
    if (cmd_i.mul_sel == MulLoLo) begin
      acc_d = prod + LcgAdd;
    end else begin
      acc_d = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    state_d = state_q;
    if (cmd_i.seed_load) begin
      state_d = seed_q ^ LcgMult;
    end else if (cmd_i.state_commit) begin
      state_d = acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LcgMult;
    end else begin
      state_q <= state_d;
    end
  end

  // restoring remainder, one draw bit per cycle, MSB first
  assign trial      = {rem_q, shift_q[DrawW-1]};
  assign trial_diff = {1'b0, trial} - {2'b00, bound_q};
  assign rem_d      = trial_diff[ValueW] ? trial[DrawW-1:0] : trial_diff[DrawW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_clear) begin
      rem_q   <= '0;
      shift_q <= acc_d[StateW-1 -: DrawW];
      cnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q   <= rem_d;
      shift_q <= {shift_q[DrawW-2:0], 1'b0};
      cnt_q   <= cnt_q + CntW'(1);
    end
  end

  // wrapped 32-bit acceptance test: draw - rem + bound - 1
  assign sum = {1'b0, draw} - {1'b0, rem_q} + {1'b0, bound_m1};

  // raw draw: top n bits, n clamped to 32, zero bits gives zero
  assign bits_c    = (bits_q > BitsW'(ValueW)) ? BitsW'(ValueW) : bits_q;
  assign raw_sh    = BitsW'(ValueW) - bits_c;
  assign raw_value = (bits_q == '0) ? '0 :
                     (state_q[StateW-1 -: ValueW] >> raw_sh[CntW-1:0]);

  assign pow_prod = (2*DrawW)'(bound_q) * (2*DrawW)'(draw);

  always_comb begin
    res_value_d = '0;
    res_err_d   = 1'b0;
    unique case (cmd_i.res_sel)
      ResZero: res_value_d = '0;
      ResErr:  res_err_d   = 1'b1;
      ResRaw:  res_value_d = raw_value;
      ResPow:  res_value_d = {1'b0, pow_prod[2*DrawW-1:DrawW]};
      ResRem:  res_value_d = {1'b0, rem_q};
      default: res_value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_value_q <= res_value_d;
      res_err_q   <= res_err_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= res_value_q;
      out_err_q   <= res_err_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_value_o       = out_value_q;
  assign out_bound_error_o = out_err_q;

  a_rem_below_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < bound_q))
    else $error("remainder not below bound during division");

  a_emit_only_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result emitted over an unaccepted one");

  a_emit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted result not valid");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_value_q == '0))
    else $error("error result carries a nonzero value");

endmodule

@@ rtl/lcg48_bounded_random.sv @@
// Top level of the 48-bit LCG random generator with raw and bounded draws.
// Sequence: seed load, zero bound and unused action go from accept to result valid
// without a multiply; a raw or power-of-two draw takes three multiply-accumulate
// steps through one shared 24x24 multiplier, then one result step.
// Other bounded draws add a bit-serial remainder over the 31 draw bits and one
// test, and each rejected draw repeats the 3 multiply steps, remainder and test.
// One item at a time; the next is accepted the cycle after the result enters the
// output register. Reset (asynchronous, active low) loads the state as seeded by zero.
module lcg48_bounded_random import lcgbr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_action_i,
  input  logic [StateW-1:0] in_seed_word_i,
  input  logic [BitsW-1:0]  in_draw_bits_i,
  input  logic [DrawW-1:0]  in_bound_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] out_value_o,
  output logic              out_bound_error_o
);

  // commands from the sequencer, status back from the datapath
  cmd_t    cmd;
  status_t status;

  lcgbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // state, multiply-accumulate, remainder unit and output register
  lcgbr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_action_i       (in_action_i),
    .in_seed_word_i    (in_seed_word_i),
    .in_draw_bits_i    (in_draw_bits_i),
    .in_bound_i        (in_bound_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_value_o       (out_value_o),
    .out_bound_error_o (out_bound_error_o)
  );

  // an item is taken only with the sequencer idle
  a_load_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_item |-> (in_valid_i && !in_stall_o))
    else $error("item loaded without handshake");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled while an item is in work");

  a_emit_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> in_stall_o)
    else $error("result emitted with no item in work");

endmodule

@@ bench/lcg48_bounded_random_tb.sv @@
// Self-checking testbench of the 48-bit LCG generator with raw and bounded draws.
module lcg48_bounded_random_tb;
  import lcgbr_pkg::*;

  // Quiet cycles allowed before the run is declared hung. This covers a long run
  // of redraws plus the long output hold-off.
  localparam int unsigned WatchdogLimit = 6000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdlePercent   = 8;

  typedef struct {
    action_e           action;
    logic [StateW-1:0] seed;
    logic [BitsW-1:0]  bits;
    logic [DrawW-1:0]  bound;
  } draw_item_t;

  typedef struct {
    logic [ValueW-1:0] value;
    logic              err;
  } draw_result_t;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_stall_o;
  logic [1:0]        in_action_i       = ActSeed;
  logic [StateW-1:0] in_seed_word_i    = '0;
  logic [BitsW-1:0]  in_draw_bits_i    = '0;
  logic [DrawW-1:0]  in_bound_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i       = 1'b0;
  logic [ValueW-1:0] out_value_o;
  logic              out_bound_error_o;

  // Golden copy of the generator state and the results still owed by the block.
  logic [StateW-1:0] lcg_model = LcgMult;
  draw_result_t      pending_draws[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  bit          idle_enable    = 1'b1;

  int unsigned n_seed = 0, n_raw = 0, n_bounded = 0, n_zero_bound = 0;
  int unsigned n_unused = 0, n_redraws = 0, n_results = 0;

  lcg48_bounded_random dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_action_i,
    .in_seed_word_i,
    .in_draw_bits_i,
    .in_bound_i,
    .out_valid_o,
    .out_stall_i,
    .out_value_o,
    .out_bound_error_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------------

  // Advance one LCG step: multiply, add, keep the low 48 bits.
  function automatic logic [StateW-1:0] lcg_advance(logic [StateW-1:0] s);
    return s * LcgMult + LcgAdd;
  endfunction

  // Take the top n bits of the state; zero bits yield zero, counts above 32 clamp.
  function automatic logic [ValueW-1:0] top_bits(logic [StateW-1:0] s,
                                                 logic [BitsW-1:0] n);
    int unsigned k;
    k = (n > ValueW) ? ValueW : n;
    if (k == 0) return '0;
    return ValueW'(s >> (StateW - k));
  endfunction

  // Work out the result of one item and update the model state.
  task automatic predict_draw(input draw_item_t it, output draw_result_t res);
    logic [ValueW-1:0] draw, rem, sum, bnd;
    logic [63:0]       prod;
    res.value = '0;
    res.err   = 1'b0;
    bnd       = ValueW'(it.bound);
    case (it.action)
      ActSeed: begin
        lcg_model = it.seed ^ LcgMult;
        n_seed++;
      end
      ActRaw: begin
        lcg_model = lcg_advance(lcg_model);
        res.value = top_bits(lcg_model, it.bits);
        n_raw++;
      end
      ActBounded: begin
        if (bnd == 0) begin
          // Zero bound: flag it and leave the state alone.
          res.err = 1'b1;
          n_zero_bound++;
        end else if ((bnd & (bnd - 1)) == 0) begin
          // Power of two: scale a 31-bit draw by the bound.
          lcg_model = lcg_advance(lcg_model);
          draw      = top_bits(lcg_model, BitsW'(DrawW));
          prod      = 64'(bnd) * 64'(draw);
          res.value = prod[62:31];
          n_bounded++;
        end else begin
          // General bound: take the remainder, redraw while the wrapped sum
          // goes negative.
          do begin
            lcg_model = lcg_advance(lcg_model);
            draw      = top_bits(lcg_model, BitsW'(DrawW));
            rem       = draw % bnd;
            sum       = draw - rem + (bnd - 1);
            if (sum[31]) n_redraws++;
          end while (sum[31]);
          res.value = rem;
          n_bounded++;
        end
      end
      default: n_unused++;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input item, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    draw_item_t   seen;
    draw_result_t want;
    if (!rst_ni) begin
      lcg_model    = LcgMult;
      quiet_cycles = 0;
    end else begin
      // Check the result first so a same-edge input never masks an empty store.
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (pending_draws.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %h error %b",
                   $time, out_value_o, out_bound_error_o);
          mismatch_count++;
        end else begin
          want = pending_draws.pop_front();
          if (out_value_o !== want.value) begin
            $display("%0t: value mismatch: expected %h, actual %h",
                     $time, want.value, out_value_o);
            mismatch_count++;
          end
          if (out_bound_error_o !== want.err) begin
            $display("%0t: bound_error mismatch: expected %b, actual %b",
                     $time, want.err, out_bound_error_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        seen.action = action_e'(in_action_i);
        seen.seed   = in_seed_word_i;
        seen.bits   = in_draw_bits_i;
        seen.bound  = in_bound_i;
        predict_draw(seen, want);
        pending_draws.push_back(want);
      end
      // Count cycles with no handshake on either side; bail out on a hang.
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, pending_draws.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= idle_enable && ($urandom_range(0, 99) < IdlePercent);
    end
  end

  // ---------------------------------------------------------------------------
  // Item sender
  // ---------------------------------------------------------------------------

  function automatic draw_item_t make_item(action_e a, logic [StateW-1:0] s,
                                           logic [BitsW-1:0] b, logic [DrawW-1:0] n);
    draw_item_t it;
    it.action = a;
    it.seed   = s;
    it.bits   = b;
    it.bound  = n;
    return it;
  endfunction

  // Offer one item, called and returning at a falling edge. Valid stays high on
  // return so back-to-back items never drop it within one step.
  task automatic send_item(input draw_item_t it);
    while (idle_enable && ($urandom_range(0, 99) < IdlePercent)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_action_i    <= it.action;
    in_seed_word_i <= it.seed;
    in_draw_bits_i <= it.bits;
    in_bound_i     <= it.bound;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk_i);
  endtask

  // Mostly draws with random content; seeds reload the sequence now and then.
  function automatic draw_item_t random_item();
    draw_item_t  it;
    int unsigned kind, pick;
    kind     = $urandom_range(0, 99);
    it.seed  = StateW'({$urandom, $urandom});
    it.bits  = ($urandom_range(0, 9) == 0) ? BitsW'($urandom_range(0, 63))
                                           : BitsW'($urandom_range(1, 32));
    pick     = $urandom_range(0, 19);
    if (pick == 0)      it.bound = '0;
    else if (pick < 5)  it.bound = DrawW'(1) << $urandom_range(0, DrawW - 1);
    else if (pick < 12) it.bound = DrawW'($urandom_range(1, 1000));
    else                it.bound = DrawW'($urandom);
    if (kind < 10)      it.action = ActSeed;
    else if (kind < 45) it.action = ActRaw;
    else if (kind < 97) it.action = ActBounded;
    else                it.action = ActUnused;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Draw straight out of reset to check the state seeded by zero.
  task automatic test_reset_state();
    send_item(make_item(ActRaw, '0, 6'd32, '0));
    send_item(make_item(ActRaw, '1, 6'd1, '1));
    send_item(make_item(ActBounded, '0, 6'd0, 31'h4000_0000));
  endtask

  // Seed extremes, including the seed that zeroes the state, and edges of the bit
  // count: zero, one, one below full width, and counts past 32 that clamp.
  task automatic test_seeds_and_bit_counts();
    send_item(make_item(ActSeed, '0, 6'd0, '0));
    send_item(make_item(ActRaw, '0, 6'd0, '0));
    send_item(make_item(ActSeed, '1, 6'd63, '1));
    send_item(make_item(ActRaw, '1, 6'd31, '1));
    send_item(make_item(ActRaw, '0, 6'd33, '0));
    send_item(make_item(ActSeed, LcgMult, 6'd5, 31'd7));
    send_item(make_item(ActRaw, '0, 6'd63, '0));
    send_item(make_item(ActRaw, '0, 6'd1, '0));
  endtask

  // Bounded draws: smallest and largest power of two, largest bound, a bound
  // that rejects often, a small odd bound, zero bound, and the unused action.
  task automatic test_bounded_corners();
    send_item(make_item(ActSeed, 48'h1234_5678_9ABC, 6'd0, '0));
    send_item(make_item(ActBounded, '0, 6'd0, 31'd1));
    send_item(make_item(ActBounded, '0, 6'd0, 31'h4000_0000));
    send_item(make_item(ActBounded, '1, 6'd63, 31'h7FFF_FFFF));
    send_item(make_item(ActBounded, '0, 6'd0, 31'h4000_0001));
    send_item(make_item(ActBounded, '0, 6'd0, 31'd3));
    send_item(make_item(ActBounded, '1, 6'd32, 31'd0));
    send_item(make_item(ActUnused, '1, 6'd32, '1));
    send_item(make_item(ActRaw, '0, 6'd32, '0));
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  // Run a stretch with neither side idling.
  task automatic test_no_idle(input int unsigned count);
    idle_enable = 1'b0;
    repeat (count) send_item(random_item());
    idle_enable = 1'b1;
  endtask

  // Hold the receiver off while items keep coming so the block fills and
  // stalls its input.
  task automatic test_output_backpressure();
    hold_request = HoldOffCycles;
    repeat (20) send_item(random_item());
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_drain_pause();
    repeat (10) send_item(random_item());
    wait_drained();
    @(negedge clk_i);
    repeat (10) send_item(random_item());
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_seeds_and_bit_counts();
    test_bounded_corners();
    test_random_mix(600);
    test_no_idle(400);
    test_output_backpressure();
    test_drain_pause();
    test_random_mix(800);

    // Let the last results out, then keep watching for stray output.
    wait_drained();
    repeat (60) @(negedge clk_i);

    $display("Covered %0d results: %0d seed loads, %0d raw draws, %0d bounded draws,",
             n_results, n_seed, n_raw, n_bounded);
    $display("  %0d redraws, %0d zero bounds, %0d unused actions, with stalls and hold-off",
             n_redraws, n_zero_bound, n_unused);
    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lcgbr_pkg.sv
rtl/lcgbr_ctrl.sv
rtl/lcgbr_dp.sv
rtl/lcg48_bounded_random.sv
bench/lcg48_bounded_random_tb.sv
